// ----- hw/rtl/hsd_pkg.sv -----
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared types and constants of the Huffman stream decoder.
// ----------------------------------------------------------------------------
package hsd_pkg;

    localparam int SYM_W            = 8;
    localparam int SYMBOL_COUNT_DEF = 256;
    localparam int LENGTH_BYTES_DEF = 8;
    localparam int MAX_RESULTS      = 8;
    localparam int BIT_IDX_W        = 3;
    localparam int RES_CNT_W        = 4;

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_TREE = 2'd1,
        PH_BODY = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_LOAD  = 9'b000000010,
        ST_DISP  = 9'b000000100,
        ST_TREE  = 9'b000001000,
        ST_LINK  = 9'b000010000,
        ST_WALK  = 9'b000100000,
        ST_EVAL  = 9'b001000000,
        ST_FIN   = 9'b010000000,
        ST_DRAIN = 9'b100000000
    } state_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic len_store;
        logic tree_step;
        logic link_step;
        logic set_body;
        logic walk_issue;
        logic eval_step;
        logic push_err;
        logic next_bit;
        logic drain_adv;
    } cmd_t;

    typedef struct packed {
        logic sof;
        logic hdr_last;
        logic tree_err;
        logic tree_link;
        logic tree_end;
        logic len_met;
        logic leaf;
        logic file_done;
        logic last_bit;
        logic res_any;
        logic drain_last;
    } sts_t;

endpackage

// ----- hw/rtl/hsd_ctrl.sv -----
// ----------------------------------------------------------------------------
// hsd_ctrl
// Sequencer: byte intake, per-bit tree build and tree walk, result drain.
// ----------------------------------------------------------------------------
module hsd_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  hsd_pkg::sts_t sts,
    output hsd_pkg::cmd_t cmd
);

    hsd_pkg::state_t state_reg, state_next;
    hsd_pkg::phase_t phase_reg, phase_next;

    always_comb begin
        hsd_pkg::phase_t ph_after;
        logic            adv;
        cmd        = '0;
        state_next = state_reg;
        phase_next = phase_reg;
        ph_after   = phase_reg;
        adv        = 1'b0;
        case (state_reg)
            hsd_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = hsd_pkg::ST_LOAD;
                end
            end
            hsd_pkg::ST_LOAD: begin
                if (sts.sof) begin
                    cmd.clear  = 1'b1;
                    phase_next = hsd_pkg::PH_LEN;
                end
                state_next = hsd_pkg::ST_DISP;
            end
            hsd_pkg::ST_DISP: begin
                case (phase_reg)
                    hsd_pkg::PH_LEN: begin
                        cmd.len_store = 1'b1;
                        if (sts.hdr_last) begin
                            phase_next = hsd_pkg::PH_TREE;
                        end
                        state_next = hsd_pkg::ST_IDLE;
                    end
                    hsd_pkg::PH_TREE: state_next = hsd_pkg::ST_TREE;
                    hsd_pkg::PH_BODY: state_next = hsd_pkg::ST_WALK;
                    default:          state_next = hsd_pkg::ST_IDLE;
                endcase
            end
            hsd_pkg::ST_TREE: begin
                cmd.tree_step = 1'b1;
                if (sts.tree_err) begin
                    cmd.push_err = 1'b1;
                    phase_next   = hsd_pkg::PH_DONE;
                    state_next   = hsd_pkg::ST_FIN;
                end else if (sts.tree_link) begin
                    state_next = hsd_pkg::ST_LINK;
                end else if (sts.tree_end) begin
                    cmd.set_body = 1'b1;
                    ph_after     = sts.len_met ? hsd_pkg::PH_DONE : hsd_pkg::PH_BODY;
                    adv          = 1'b1;
                end else begin
                    adv = 1'b1;
                end
            end
            hsd_pkg::ST_LINK: begin
                cmd.link_step = 1'b1;
                adv           = 1'b1;
            end
            hsd_pkg::ST_WALK: begin
                cmd.walk_issue = 1'b1;
                state_next     = hsd_pkg::ST_EVAL;
            end
            hsd_pkg::ST_EVAL: begin
                cmd.eval_step = 1'b1;
                if (sts.leaf && sts.file_done) begin
                    ph_after = hsd_pkg::PH_DONE;
                end
                adv = 1'b1;
            end
            hsd_pkg::ST_FIN: begin
                state_next = sts.res_any ? hsd_pkg::ST_DRAIN : hsd_pkg::ST_IDLE;
            end
            hsd_pkg::ST_DRAIN: begin
                if (m_tready) begin
                    cmd.drain_adv = 1'b1;
                    if (sts.drain_last) begin
                        state_next = hsd_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = hsd_pkg::ST_IDLE;
        endcase
        if (adv) begin
            phase_next = ph_after;
            if (sts.last_bit || ph_after == hsd_pkg::PH_DONE) begin
                state_next = hsd_pkg::ST_FIN;
            end else begin
                cmd.next_bit = 1'b1;
                state_next   = (ph_after == hsd_pkg::PH_TREE) ? hsd_pkg::ST_TREE
                                                              : hsd_pkg::ST_WALK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hsd_pkg::ST_IDLE;
            phase_reg <= hsd_pkg::PH_LEN;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    assign s_tready = (state_reg == hsd_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == hsd_pkg::ST_DRAIN);

endmodule

// ----- hw/rtl/hsd_dp.sv -----
// ----------------------------------------------------------------------------
// hsd_dp
// Datapath: length header, node table and pending stack, walk, result buffer.
// ----------------------------------------------------------------------------
module hsd_dp #(
    parameter int SYMBOL_COUNT = hsd_pkg::SYMBOL_COUNT_DEF,
    parameter int LENGTH_BYTES = hsd_pkg::LENGTH_BYTES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  hsd_pkg::cmd_t             cmd,
    output hsd_pkg::sts_t             sts,
    input  logic [hsd_pkg::SYM_W-1:0] in_byte,
    input  logic                      in_sof,
    output logic [hsd_pkg::SYM_W-1:0] out_sym,
    output logic                      out_status,
    output logic                      out_done,
    output logic                      out_last
);

    localparam int SW         = hsd_pkg::SYM_W;
    localparam int NODE_DEPTH = 2 * SYMBOL_COUNT - 1;
    localparam int AW         = $clog2(NODE_DEPTH);
    localparam int NCW        = $clog2(NODE_DEPTH + 1);
    localparam int SAW        = $clog2(SYMBOL_COUNT);
    localparam int SPW        = $clog2(SYMBOL_COUNT + 1);
    localparam int LW         = SW * LENGTH_BYTES;
    localparam int HW         = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
    localparam int NW         = 1 + AW + SW;
    localparam int BW         = hsd_pkg::BIT_IDX_W;
    localparam int RW         = hsd_pkg::RES_CNT_W;
    localparam int RN         = hsd_pkg::MAX_RESULTS;

    logic [SW-1:0]  byte_reg, byte_next;
    logic           sof_reg, sof_next;
    logic [BW-1:0]  bit_idx_reg, bit_idx_next;
    logic [HW-1:0]  hdr_reg, hdr_next;
    logic [LW-1:0]  orig_reg, orig_next;
    logic [LW-1:0]  bw_reg, bw_next;
    logic [NCW-1:0] nc_reg, nc_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [3:0]     bl_reg, bl_next;
    logic [SW-1:0]  shift_reg, shift_next;
    logic [AW-1:0]  cur_reg, cur_next;
    logic [NW-1:0]  cur_entry_reg, cur_entry_next;
    logic [NW-1:0]  root_reg, root_next;
    logic [RW-1:0]  res_cnt_reg, res_cnt_next;
    logic [BW-1:0]  drain_reg, drain_next;

    logic [NW-1:0]  node_mem [NODE_DEPTH];
    logic [NW-1:0]  node_rd_reg;
    logic [AW-1:0]  stk_mem [SYMBOL_COUNT];
    logic [AW-1:0]  stk_rd_reg;

    logic [SW-1:0]  res_sym_reg  [RN];
    logic           res_st_reg   [RN];
    logic           res_done_reg [RN];

    logic           bit_val;
    logic [SW-1:0]  sym_shifted;
    logic           in_sym;
    logic           leaf_fin;
    logic           tbl_room;
    logic           stk_room;
    logic [AW-1:0]  nc_idx;
    logic [SPW-1:0] sp_m1;
    logic [AW-1:0]  walk_next;
    logic [LW-1:0]  bw_inc;
    logic           tbl_we;
    logic [AW-1:0]  tbl_waddr;
    logic [NW-1:0]  tbl_wdata;
    logic           stk_we;
    logic           push;
    logic [SW-1:0]  push_sym;
    logic           push_st;
    logic           push_done;

    assign bit_val     = byte_reg[bit_idx_reg];
    assign sym_shifted = {shift_reg[SW-2:0], bit_val};
    assign in_sym      = (bl_reg != 4'd0);
    assign leaf_fin    = (bl_reg == 4'd1);
    assign tbl_room    = (nc_reg < NCW'(NODE_DEPTH));
    assign stk_room    = (sp_reg < SPW'(SYMBOL_COUNT));
    assign nc_idx      = nc_reg[AW-1:0];
    assign sp_m1       = sp_reg - 1'b1;
    assign walk_next   = bit_val ? cur_entry_reg[AW+SW-1:SW] : AW'(cur_reg + 1'b1);
    assign bw_inc      = bw_reg + 1'b1;

    assign sts.sof        = sof_reg;
    assign sts.hdr_last   = (hdr_reg == HW'(LENGTH_BYTES - 1));
    assign sts.tree_err   = in_sym ? (leaf_fin && sp_reg == '0 && nc_reg == NCW'(1))
                                   : (!tbl_room || (!bit_val && !stk_room));
    assign sts.tree_link  = in_sym && leaf_fin && sp_reg != '0;
    assign sts.tree_end   = in_sym && leaf_fin && sp_reg == '0 && nc_reg != NCW'(1);
    assign sts.len_met    = (bw_reg == orig_reg);
    assign sts.leaf       = node_rd_reg[NW-1];
    assign sts.file_done  = (bw_inc == orig_reg);
    assign sts.last_bit   = (bit_idx_reg == '0);
    assign sts.res_any    = (res_cnt_reg != '0);
    assign sts.drain_last = (RW'(drain_reg) == res_cnt_reg - 1'b1);

    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = nc_idx;
        tbl_wdata = '0;
        if (cmd.tree_step) begin
            if (in_sym && leaf_fin) begin
                tbl_we    = 1'b1;
                tbl_waddr = AW'(nc_reg - 1'b1);
                tbl_wdata = {1'b1, {AW{1'b0}}, sym_shifted};
            end else if (!in_sym && tbl_room) begin
                tbl_we = 1'b1;
            end
        end else if (cmd.link_step) begin
            tbl_we    = 1'b1;
            tbl_waddr = stk_rd_reg;
            tbl_wdata = {1'b0, nc_idx, {SW{1'b0}}};
        end
    end

    assign stk_we = cmd.tree_step && !in_sym && tbl_room && !bit_val && stk_room;

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            node_mem[tbl_waddr] <= tbl_wdata;
        end
        node_rd_reg <= node_mem[walk_next];
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[sp_reg[SAW-1:0]] <= nc_idx;
        end
        stk_rd_reg <= stk_mem[sp_m1[SAW-1:0]];
    end

    always_comb begin
        push      = 1'b0;
        push_sym  = '0;
        push_st   = 1'b0;
        push_done = 1'b0;
        if (cmd.push_err) begin
            push    = 1'b1;
            push_st = 1'b1;
        end else if (cmd.eval_step && sts.leaf) begin
            push      = 1'b1;
            push_sym  = node_rd_reg[SW-1:0];
            push_done = sts.file_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            res_sym_reg[res_cnt_reg[BW-1:0]]  <= push_sym;
            res_st_reg[res_cnt_reg[BW-1:0]]   <= push_st;
            res_done_reg[res_cnt_reg[BW-1:0]] <= push_done;
        end
    end

    always_comb begin
        byte_next      = byte_reg;
        sof_next       = sof_reg;
        bit_idx_next   = bit_idx_reg;
        hdr_next       = hdr_reg;
        orig_next      = orig_reg;
        bw_next        = bw_reg;
        nc_next        = nc_reg;
        sp_next        = sp_reg;
        bl_next        = bl_reg;
        shift_next     = shift_reg;
        cur_next       = cur_reg;
        cur_entry_next = cur_entry_reg;
        root_next      = root_reg;
        res_cnt_next   = res_cnt_reg;
        drain_next     = drain_reg;

        if (cmd.load) begin
            byte_next    = in_byte;
            sof_next     = in_sof;
            bit_idx_next = '1;
            res_cnt_next = '0;
            drain_next   = '0;
        end
        if (cmd.clear) begin
            hdr_next   = '0;
            orig_next  = '0;
            bw_next    = '0;
            nc_next    = '0;
            sp_next    = '0;
            bl_next    = '0;
            shift_next = '0;
            cur_next   = '0;
        end
        if (cmd.len_store) begin
            orig_next[{hdr_reg, 3'b000} +: SW] = byte_reg;
            if (!sts.hdr_last) begin
                hdr_next = hdr_reg + 1'b1;
            end
        end
        if (cmd.tree_step) begin
            if (in_sym) begin
                shift_next = sym_shifted;
                bl_next    = bl_reg - 1'b1;
                if (leaf_fin && sp_reg != '0) begin
                    sp_next = sp_m1;
                end
            end else if (tbl_room) begin
                nc_next = nc_reg + 1'b1;
                if (bit_val) begin
                    bl_next    = 4'd8;
                    shift_next = '0;
                end else if (stk_room) begin
                    sp_next = sp_reg + 1'b1;
                end
            end
        end
        if (cmd.set_body) begin
            cur_next       = '0;
            cur_entry_next = root_reg;
        end
        if (cmd.walk_issue) begin
            cur_next = walk_next;
        end
        if (cmd.eval_step) begin
            if (sts.leaf) begin
                bw_next        = bw_inc;
                cur_next       = '0;
                cur_entry_next = root_reg;
            end else begin
                cur_entry_next = node_rd_reg;
            end
        end
        if (push) begin
            res_cnt_next = res_cnt_reg + 1'b1;
        end
        if (cmd.next_bit) begin
            bit_idx_next = bit_idx_reg - 1'b1;
        end
        if (cmd.drain_adv) begin
            drain_next = drain_reg + 1'b1;
        end
        if (tbl_we && tbl_waddr == '0) begin
            root_next = tbl_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg      <= '0;
            sof_reg       <= 1'b0;
            bit_idx_reg   <= '0;
            hdr_reg       <= '0;
            orig_reg      <= '0;
            bw_reg        <= '0;
            nc_reg        <= '0;
            sp_reg        <= '0;
            bl_reg        <= '0;
            shift_reg     <= '0;
            cur_reg       <= '0;
            cur_entry_reg <= '0;
            root_reg      <= '0;
            res_cnt_reg   <= '0;
            drain_reg     <= '0;
        end else begin
            byte_reg      <= byte_next;
            sof_reg       <= sof_next;
            bit_idx_reg   <= bit_idx_next;
            hdr_reg       <= hdr_next;
            orig_reg      <= orig_next;
            bw_reg        <= bw_next;
            nc_reg        <= nc_next;
            sp_reg        <= sp_next;
            bl_reg        <= bl_next;
            shift_reg     <= shift_next;
            cur_reg       <= cur_next;
            cur_entry_reg <= cur_entry_next;
            root_reg      <= root_next;
            res_cnt_reg   <= res_cnt_next;
            drain_reg     <= drain_next;
        end
    end

    assign out_sym    = res_sym_reg[drain_reg];
    assign out_status = res_st_reg[drain_reg];
    assign out_done   = res_done_reg[drain_reg];
    assign out_last   = sts.drain_last;

endmodule

// ----- hw/rtl/huffman_stream_decoder_top.sv -----
// ----------------------------------------------------------------------------
// huffman_stream_decoder_top
// Huffman decoder for a byte stream with length header and preorder tree.
//
//   channel  direction  tdata            tuser                 tlast
//   s_       in         stream_byte      start_of_file         -
//   m_       out        symbol_out       status, file_done     last_of_run
//
// A byte passes intake and dispatch, then per bit a tree step in the header
// (plus a link step when a right child is linked through the pending stack)
// and a walk issue and an evaluation in the body, bound by the registered node
// table read; then the byte is closed and the results drain, one per m_ beat.
// Length bytes and bytes after the end pass only intake and dispatch.
// Reset is synchronous; the node table and stack need no clearing pass.
// A stalled m_ side holds the drain and the s_ side until all results leave.
// ----------------------------------------------------------------------------
module huffman_stream_decoder_top #(
    parameter int SYMBOL_COUNT = hsd_pkg::SYMBOL_COUNT_DEF,
    parameter int LENGTH_BYTES = hsd_pkg::LENGTH_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] stream_byte
    input  logic       s_tuser,   // [0] start_of_file
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] symbol_out
    output logic [1:0] m_tuser,   // [0] status, [1] file_done
    output logic       m_tlast
);

    hsd_pkg::cmd_t cmd;
    hsd_pkg::sts_t sts;
    logic          out_status;
    logic          out_done;

    hsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hsd_dp #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .LENGTH_BYTES (LENGTH_BYTES)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_byte    (s_tdata),
        .in_sof     (s_tuser),
        .out_sym    (m_tdata),
        .out_status (out_status),
        .out_done   (out_done),
        .out_last   (m_tlast)
    );

    assign m_tuser = {out_done, out_status};

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while results drain");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transfer accepted back to back");

    a_err_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (!m_tuser[1] && m_tdata == 8'd0))
        else $error("error result carries data");

endmodule
